// ----- src/aled_pkg.sv -----
// shared types and constants for the addressable led bit encoder
package aled_pkg;

  localparam int BITS_PER_PIXEL = 24;
  localparam int DUTY_W         = 8;
  localparam int CFG_IDX_W      = 1;
  localparam int SLOT_W         = $clog2(BITS_PER_PIXEL + 1);

  localparam logic [CFG_IDX_W-1:0] REG_ONE_BIT_DUTY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_BIT_DUTY = 1'd1;

  localparam logic [SLOT_W-1:0] LAST_BIT_SLOT   = SLOT_W'(BITS_PER_PIXEL - 1);
  localparam logic [SLOT_W-1:0] TERMINATOR_SLOT = SLOT_W'(BITS_PER_PIXEL);

  // classified pixel as it waits between front and back
  typedef struct packed {
    logic [BITS_PER_PIXEL-1:0] bits;
    logic                      last;
  } pix_t;

endpackage

// ----- src/aled_in_if.sv -----
// pixel request channel
interface aled_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] color_word;
  logic        last_pixel;

  modport source (output valid, output color_word, output last_pixel, input ready);
  modport sink   (input valid, input color_word, input last_pixel, output ready);
endinterface

// ----- src/aled_out_if.sv -----
// duty result channel
interface aled_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty;
  logic       end_of_pixel;
  logic       end_of_frame;

  modport source (output valid, output duty, output end_of_pixel, output end_of_frame,
                  input ready);
  modport sink   (input valid, input duty, input end_of_pixel, input end_of_frame,
                  output ready);
endinterface

// ----- src/aled_front.sv -----
// front end: accepts pixel requests and turns them into grb bit strings
module aled_front (
  aled_in_if.sink       pixel,
  input  logic          q_full,
  output logic          q_push,
  output aled_pkg::pix_t q_data
);
  import aled_pkg::*;

  logic [7:0] inten;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  assign inten = pixel.color_word[31:24];
  assign red   = pixel.color_word[23:16];
  assign green = pixel.color_word[15:8];
  assign blue  = pixel.color_word[7:0];

  assign pixel.ready = !q_full;
  assign q_push      = pixel.valid && !q_full;

  always_comb begin
    // zero intensity blanks the pixel
    q_data.bits = (inten == 8'd0) ? '0 : {green, red, blue};
    q_data.last = pixel.last_pixel;
  end

endmodule

// ----- src/aled_fifo.sv -----
// two-entry queue of classified pixels
module aled_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  aled_pkg::pix_t push_data,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output aled_pkg::pix_t head_data
);
  import aled_pkg::*;

  pix_t       entries [2];
  logic       head;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head_data = entries[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (pop) begin
        head <= !head;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[head ^ count[0]] <= push_data;
    end
  end

endmodule

// ----- src/aled_back.sv -----
// back end: serializes one pixel into duty slots behind an output register
module aled_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [aled_pkg::DUTY_W-1:0] one_bit_duty,
  input  logic [aled_pkg::DUTY_W-1:0] zero_bit_duty,
  input  logic                      q_not_empty,
  input  aled_pkg::pix_t            q_data,
  output logic                      q_pop,
  aled_out_if.source                result
);
  import aled_pkg::*;

  logic                      active;
  logic [BITS_PER_PIXEL-1:0] bits;
  logic                      last;
  logic [SLOT_W-1:0]         slot;
  logic                      advance;
  logic                      done;
  logic                      out_valid;
  logic [DUTY_W-1:0]         out_duty;
  logic                      out_eop;
  logic                      out_eof;

  assign advance = !out_valid || result.ready;
  assign done    = (slot == LAST_BIT_SLOT && !last) || (slot == TERMINATOR_SLOT);
  assign q_pop   = advance && (!active || done) && q_not_empty;

  assign result.valid        = out_valid;
  assign result.duty         = out_duty;
  assign result.end_of_pixel = out_eop;
  assign result.end_of_frame = out_eof;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      slot      <= '0;
    end else if (advance) begin
      out_valid <= active;
      if (!active || done) begin
        active <= q_not_empty;
        slot   <= '0;
      end else begin
        slot <= slot + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (slot == TERMINATOR_SLOT) begin
        out_duty <= '0;
        out_eop  <= 1'b1;
        out_eof  <= 1'b1;
      end else begin
        out_duty <= bits[BITS_PER_PIXEL-1] ? one_bit_duty : zero_bit_duty;
        out_eop  <= (slot == LAST_BIT_SLOT) && !last;
        out_eof  <= 1'b0;
      end
      if (q_pop) begin
        bits <= q_data.bits;
        last <= q_data.last;
      end else begin
        bits <= {bits[BITS_PER_PIXEL-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- src/addressable_led_bit_encoder.sv -----
// addressable led bit encoder top level: config registers, front, queue and back
// an idle request goes via the queue and the back's bit register to the output register
// throughput: one duty per cycle while result is ready, 24 slots per pixel, 25 for a frame's last
// the rate is set by the back end serializer: one bit slot per cycle unless result stalls
// a two-entry queue lets the front take requests while the back still serializes
// reset (synchronous, active high) clears both duty registers, the queue and the back end
module addressable_led_bit_encoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [aled_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aled_pkg::DUTY_W-1:0]    cfg_data,
  aled_in_if.sink                        pixel,
  aled_out_if.source                     result
);
  import aled_pkg::*;

  // duty registers; the user writes them only while the block is idle, the block itself does not enforce it
  logic [DUTY_W-1:0] one_bit_duty;
  logic [DUTY_W-1:0] zero_bit_duty;

  // queue hookup
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_not_empty;
  pix_t q_in;
  pix_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      one_bit_duty  <= '0;
      zero_bit_duty <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ONE_BIT_DUTY:  one_bit_duty  <= cfg_data;
        REG_ZERO_BIT_DUTY: zero_bit_duty <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: take the request, blank or reorder to grb
  aled_front u_front (
    .pixel  (pixel),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  // short queue decouples request intake from serialization
  aled_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_data (q_head)
  );

  // back: msb-first bit slots, terminator after the frame's last pixel
  aled_back u_back (
    .clk           (clk),
    .rst           (rst),
    .one_bit_duty  (one_bit_duty),
    .zero_bit_duty (zero_bit_duty),
    .q_not_empty   (q_not_empty),
    .q_data        (q_head),
    .q_pop         (q_pop),
    .result        (result)
  );

endmodule

// ----- tb/addressable_led_bit_encoder_tb.sv -----
// testbench for the addressable led bit encoder: directed and random pixels against a predictor
`timescale 1ns / 100ps

module addressable_led_bit_encoder_tb;
  import aled_pkg::*;

  // cycles with no request accepted on either side before the run is called hung
  localparam int WATCHDOG_LIMIT = 3000;
  // cycles allowed after the last duty so a stray extra one is still caught
  localparam int SETTLE_CYCLES  = 8;
  // long receiver hold-off so the two-entry queue fills and the input stalls
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_PIXELS   = 196;

  // one expected duty slot on the result channel
  typedef struct {
    logic [DUTY_W-1:0] duty;
    logic              end_of_pixel;
    logic              end_of_frame;
  } duty_slot_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DUTY_W-1:0]    cfg_data;

  aled_in_if  pix_if ();
  aled_out_if res_if ();

  addressable_led_bit_encoder u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pix_if.sink),
    .result    (res_if.source)
  );

  // own copy of the two duty registers, updated as each write lands
  logic [DUTY_W-1:0] one_duty;
  logic [DUTY_W-1:0] zero_duty;

  // duty slots still owed by the block, oldest first
  duty_slot_t pending_slots[$];

  // idling knobs, in percent per cycle
  int send_idle_pct;
  int recv_stall_pct;
  // receiver hold-off, counted down in the receiver process
  int hold_left;

  int errors;
  int pixels_sent;
  int slots_checked;
  int frames_closed;
  int idle_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // expected duty slots for one pixel: black on zero intensity, else g,r,b msb first
  function automatic void encode_pixel(input logic [31:0] word, input logic last);
    logic [BITS_PER_PIXEL-1:0] grb;
    duty_slot_t slot;
    int k;
    grb = (word[31:24] == 8'd0) ? '0 : {word[15:8], word[23:16], word[7:0]};
    for (k = BITS_PER_PIXEL - 1; k >= 0; k--) begin
      slot.duty         = grb[k] ? one_duty : zero_duty;
      slot.end_of_pixel = !last && (k == 0);
      slot.end_of_frame = 1'b0;
      pending_slots.push_back(slot);
    end
    // terminator closes the frame with a zero duty
    if (last) begin
      slot.duty         = '0;
      slot.end_of_pixel = 1'b1;
      slot.end_of_frame = 1'b1;
      pending_slots.push_back(slot);
    end
  endfunction

  // register write; only called while the block is idle
  task automatic write_duty(input logic [CFG_IDX_W-1:0] idx, input logic [DUTY_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ONE_BIT_DUTY:  one_duty  = val;
      REG_ZERO_BIT_DUTY: zero_duty = val;
      default: ;
    endcase
  endtask

  // offer one pixel request, with random idle cycles ahead of it, until accepted
  task automatic send_pixel(input logic [31:0] word, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(negedge clk);
    end
    pix_if.valid      <= 1'b1;
    pix_if.color_word <= word;
    pix_if.last_pixel <= last;
    do @(posedge clk); while (!pix_if.ready);
    encode_pixel(word, last);
    pixels_sent++;
  endtask

  // drop valid and wait until every owed duty slot has come out
  task automatic wait_drained();
    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (pending_slots.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_duties(input logic [DUTY_W-1:0] one_val, input logic [DUTY_W-1:0] zero_val);
    write_duty(REG_ONE_BIT_DUTY, one_val);
    write_duty(REG_ZERO_BIT_DUTY, zero_val);
  endtask

  // random pixel word, biased toward black, minimum and full intensity now and then
  function automatic logic [31:0] random_word();
    logic [31:0] word;
    word = $urandom();
    case ($urandom_range(7))
      0: word[31:24] = 8'd0;
      1: word[31:24] = 8'd1;
      2: word[31:24] = 8'hff;
      default: ;
    endcase
    return word;
  endfunction

  // frames of one to eight pixels, the final pixel of each frame flagged
  task automatic send_random_frames(input int count);
    int frame_len;
    int i;
    while (count > 0) begin
      frame_len = $urandom_range(1, 8);
      if (frame_len > count) frame_len = count;
      for (i = 0; i < frame_len; i++) begin
        // now and then a frame is cut short by a stray last flag
        send_pixel(random_word(), (i == frame_len - 1) || ($urandom_range(19) == 0));
      end
      count -= frame_len;
    end
  endtask

  // duties straight out of reset are both zero, so every slot is zero
  task automatic test_reset_duties();
    send_pixel(32'hffffffff, 1'b0);
    send_pixel(32'h12345678, 1'b1);
    wait_drained();
  endtask

  // field extremes, byte order, black pixels and frame terminators
  task automatic test_directed_pixels();
    set_duties(8'hff, 8'h00);
    send_pixel(32'h00000000, 1'b0);
    send_pixel(32'hffffffff, 1'b0);
    // zero intensity blanks the color bytes
    send_pixel(32'h00ffffff, 1'b0);
    // single bits show the g,r,b reordering
    send_pixel(32'h01800000, 1'b0);
    send_pixel(32'hff008000, 1'b0);
    send_pixel(32'h80000001, 1'b0);
    send_pixel(32'h7f010203, 1'b1);
    // back-to-back single-pixel frames
    send_pixel(32'hffffffff, 1'b1);
    send_pixel(32'h00000000, 1'b1);
    wait_drained();

    // inverted duties
    set_duties(8'h00, 8'hff);
    send_pixel(32'hffffffff, 1'b0);
    send_pixel(32'h00000000, 1'b1);
    send_pixel(32'ha5c3f00f, 1'b1);
    wait_drained();

    // mid-range duties with alternating bits
    set_duties(8'h96, 8'h69);
    send_pixel(32'h80ff00aa, 1'b0);
    send_pixel(32'h0155aa33, 1'b1);
    wait_drained();
  endtask

  // random frames across the idling phases, duties changed between phases
  task automatic test_random_frames();
    int phase;
    int per_phase;
    per_phase = RANDOM_PIXELS / 4;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          set_duties(8'hff, 8'h00);
        end
        1: begin
          send_idle_pct = 76; recv_stall_pct = 0;
          set_duties(DUTY_W'($urandom()), DUTY_W'($urandom()));
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 76;
          set_duties(DUTY_W'($urandom()), DUTY_W'($urandom()));
        end
        default: begin
          send_idle_pct = 38; recv_stall_pct = 38;
          set_duties(8'h00, 8'hff);
        end
      endcase
      send_random_frames(per_phase);
      wait_drained();
    end
  endtask

  // receiver holds off while pixels keep coming, then the sender waits for a full drain
  task automatic test_backpressure();
    int i;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_duties(8'h3c, 8'hc3);
    hold_left = HOLD_OFF_CYCLES;
    for (i = 0; i < 8; i++) send_pixel(random_word(), i == 7);
    wait_drained();
    for (i = 0; i < 3; i++) send_pixel(random_word(), i == 2);
    wait_drained();
  endtask

  // result side: ready changes on the falling edge, random stalls or a hold-off
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare every accepted duty slot with the oldest expectation
  always @(posedge clk) begin
    duty_slot_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_slots.size() == 0) begin
        $display("%0t: unexpected duty slot, actual duty %0d eop %0b eof %0b", $time,
                 res_if.duty, res_if.end_of_pixel, res_if.end_of_frame);
        errors++;
      end else begin
        want = pending_slots.pop_front();
        slots_checked++;
        if (res_if.end_of_frame) frames_closed++;
        if (res_if.duty !== want.duty) begin
          $display("%0t: duty mismatch, expected %0d, actual %0d", $time,
                   want.duty, res_if.duty);
          errors++;
        end
        if (res_if.end_of_pixel !== want.end_of_pixel) begin
          $display("%0t: end_of_pixel mismatch, expected %0b, actual %0b", $time,
                   want.end_of_pixel, res_if.end_of_pixel);
          errors++;
        end
        if (res_if.end_of_frame !== want.end_of_frame) begin
          $display("%0t: end_of_frame mismatch, expected %0b, actual %0b", $time,
                   want.end_of_frame, res_if.end_of_frame);
          errors++;
        end
      end
    end
  end

  // hang detector: cycles with no request accepted on either channel
  always @(posedge clk) begin
    if (rst || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d duty slots still owed", $time, pending_slots.size());
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    pix_if.valid      = 1'b0;
    pix_if.color_word = '0;
    pix_if.last_pixel = 1'b0;
    one_duty          = '0;
    zero_duty         = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_left         = 0;
    errors            = 0;
    pixels_sent       = 0;
    slots_checked     = 0;
    frames_closed     = 0;
    idle_cycles       = 0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_reset_duties();
    test_directed_pixels();
    test_random_frames();
    test_backpressure();

    $display("%0d pixels sent, %0d duty slots checked, %0d frames terminated",
             pixels_sent, slots_checked, frames_closed);
    $display("duty extremes and mid values, four idling phases, one long result hold-off");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- addressable_led_bit_encoder.f -----
src/aled_pkg.sv
src/aled_in_if.sv
src/aled_out_if.sv
src/aled_front.sv
src/aled_fifo.sv
src/aled_back.sv
src/addressable_led_bit_encoder.sv
tb/addressable_led_bit_encoder_tb.sv
